@@ design/cht_pkg.sv @@
// Shared types and constants for the chained hash table.
package cht_pkg;

  // Field widths fixed by the port list
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 31;
  localparam int STATUS_W = 2;
  localparam int BUCKET_W = 4;
  localparam int TOTAL_W  = 7;

  // Remainder is built one byte of the zero-padded key per step
  localparam int DIGIT_W   = 8;
  localparam int KEY_PAD_W = 32;
  localparam int MOD_STEPS = KEY_PAD_W / DIGIT_W;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);

  // Operation codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic                load;
    logic                mod_step;
    logic                idx_clr;
    logic                idx_inc;
    logic                fill_load;
    logic                ins_wr;
    logic                shift_wr;
    logic                del_fin;
    logic                done;
    logic [STATUS_W-1:0] status;
  } ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_insert;
    logic is_delete;
    logic fill_full;
    logic scan_end;
    logic hit;
  } sts_t;

endpackage

@@ design/cht_ctrl.sv @@
// Sequencer for the chained hash table: remainder steps, bucket scan and compaction.
module cht_ctrl
  import cht_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output ctl_t ctl
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOD   = 3'd1;
  localparam logic [2:0] S_FRD   = 3'd2;
  localparam logic [2:0] S_FILL  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_SHIFT = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic [MOD_CNT_W-1:0] cnt_r, cnt_nxt;

  // State and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ctl       = '0;
    ctl.status = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        ctl.mod_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == MOD_CNT_W'(MOD_STEPS - 1)) begin
          state_nxt = S_FRD;
        end
      end
      S_FRD: begin
        // point the slot read at the head of the bucket
        ctl.idx_clr = 1'b1;
        state_nxt   = S_FILL;
      end
      S_FILL: begin
        ctl.fill_load = 1'b1;
        if (sts.is_insert) begin
          ctl.done  = 1'b1;
          state_nxt = S_IDLE;
          if (sts.fill_full) begin
            ctl.status = ST_FULL;
          end else begin
            ctl.ins_wr = 1'b1;
          end
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_end) begin
          ctl.done   = 1'b1;
          ctl.status = ST_MISS;
          state_nxt  = S_IDLE;
        end else if (sts.hit) begin
          if (sts.is_delete) begin
            ctl.idx_inc = 1'b1;
            state_nxt   = S_SHIFT;
          end else begin
            ctl.done  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          ctl.idx_inc = 1'b1;
        end
      end
      S_SHIFT: begin
        // move later keys down one slot until the end of the bucket
        if (sts.scan_end) begin
          ctl.del_fin = 1'b1;
          ctl.done    = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          ctl.shift_wr = 1'b1;
          ctl.idx_inc  = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/cht_dpath.sv @@
// Datapath for the chained hash table: remainder unit, slot and fill memories, counters.
module cht_dpath
  import cht_pkg::*;
#(
  parameter int BUCKETS      = 11,
  parameter int BUCKET_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [KEY_W-1:0]    in_key,
  input  ctl_t                ctl,
  output sts_t                sts,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [BUCKET_W-1:0] out_bucket,
  output logic [TOTAL_W-1:0]  out_total
);

  localparam int NSLOT = BUCKETS * BUCKET_DEPTH;
  localparam int RW    = $clog2(BUCKETS);
  localparam int VW    = RW + DIGIT_W;
  localparam int FW    = $clog2(BUCKET_DEPTH + 1);
  localparam int AW    = $clog2(NSLOT);
  localparam int TW    = $clog2(NSLOT + 1);

  logic [CMD_W-1:0]   cmd_r;
  logic [KEY_W-1:0]   key_r;
  logic [KEY_PAD_W-1:0] kshift_r;
  logic [RW-1:0]      rem_r;
  logic [FW-1:0]      idx_r, idx_nxt, rd_idx;
  logic [FW-1:0]      fill_q, fill_r;
  logic [TW-1:0]      total_r, total_nxt;
  logic [BUCKETS-1:0] fvalid_r;
  logic [KEY_W-1:0]   slot_q;
  logic [AW-1:0]      base, rd_addr, wr_addr;
  logic [KEY_W-1:0]   wr_data;
  logic               wr_en;
  logic               out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [RW-1:0]      out_bucket_r;
  logic [TW-1:0]      out_total_r;
  logic [RW+BUCKET_W-1:0] bucket_ext;
  logic [TW+TOTAL_W-1:0]  total_ext;

  logic [KEY_W-1:0] slot_mem [NSLOT];
  logic [FW-1:0]    fill_mem [BUCKETS];

  // One remainder step: fold in a byte, then reduce by shifted bucket counts
  function automatic logic [RW-1:0] mod_step(input logic [RW-1:0] rem,
                                             input logic [DIGIT_W-1:0] digit);
    logic [VW-1:0] v;
    logic [VW-1:0] m;
    v = {rem, digit};
    for (int j = DIGIT_W - 1; j >= 0; j--) begin
      m = VW'(BUCKETS) << j;
      if (v >= m) begin
        v = v - m;
      end
    end
    return v[RW-1:0];
  endfunction

  // Latch the item and run the remainder one byte per step
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r    <= in_cmd;
      key_r    <= in_key;
      kshift_r <= {1'b0, in_key};
      rem_r    <= '0;
    end else if (ctl.mod_step) begin
      rem_r    <= mod_step(rem_r, kshift_r[KEY_PAD_W-1 -: DIGIT_W]);
      kshift_r <= {kshift_r[KEY_PAD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end
  end

  // Advance the scan index
  always_comb begin
    idx_nxt = idx_r;
    if (ctl.idx_clr) begin
      idx_nxt = '0;
    end else if (ctl.idx_inc) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (ctl.fill_load) begin
      fill_r <= fill_q;
    end
  end

  // Slot addressing: bucket base plus index, read clamped to the bucket
  assign base    = AW'(rem_r) * AW'(BUCKET_DEPTH);
  assign rd_idx  = (idx_nxt >= FW'(BUCKET_DEPTH)) ? FW'(BUCKET_DEPTH - 1) : idx_nxt;
  assign rd_addr = base + AW'(rd_idx);
  assign wr_en   = ctl.ins_wr | ctl.shift_wr;
  assign wr_addr = ctl.ins_wr ? (base + AW'(fill_q)) : (base + AW'(idx_r) - 1'b1);
  assign wr_data = ctl.ins_wr ? key_r : slot_q;

  // Slot memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    slot_q <= slot_mem[rd_addr];
  end

  // Fill memory; an unwritten bucket reads as empty
  always_ff @(posedge clk) begin
    if (ctl.ins_wr) begin
      fill_mem[rem_r] <= fill_q + 1'b1;
    end else if (ctl.del_fin) begin
      fill_mem[rem_r] <= fill_r - 1'b1;
    end
    fill_q <= fvalid_r[rem_r] ? fill_mem[rem_r] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fvalid_r <= '0;
    end else if (ctl.ins_wr || ctl.del_fin) begin
      fvalid_r[rem_r] <= 1'b1;
    end
  end

  // Total key count
  always_comb begin
    total_nxt = total_r;
    if (ctl.ins_wr) begin
      total_nxt = total_r + 1'b1;
    end else if (ctl.del_fin) begin
      total_nxt = total_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      total_r     <= total_nxt;
      out_valid_r <= ctl.done;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (ctl.done) begin
      out_status_r <= ctl.status;
      out_bucket_r <= rem_r;
      out_total_r  <= total_nxt;
    end
  end

  // Status back to the controller
  assign sts.is_insert = (cmd_r == CMD_INSERT);
  assign sts.is_delete = (cmd_r == CMD_DELETE);
  assign sts.fill_full = (fill_q == FW'(BUCKET_DEPTH));
  assign sts.scan_end  = (idx_r == fill_r);
  assign sts.hit       = (slot_q == key_r);

  // Mask results to the port widths
  assign bucket_ext = {{BUCKET_W{1'b0}}, out_bucket_r};
  assign total_ext  = {{TOTAL_W{1'b0}}, out_total_r};
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_bucket = bucket_ext[BUCKET_W-1:0];
  assign out_total  = total_ext[TOTAL_W-1:0];

endmodule

@@ design/chained_hash_table.sv @@
// Chained hash table: each item runs four remainder steps, a bucket-head read and a fill
// load. Search and delete then compare the bucket entries in turn and check the end of the
// bucket on a miss; a delete moves each later key down one slot, then closes the bucket.
// One item at a time; start is taken whenever busy is low.
// Results show for one cycle on out_valid; the receiver cannot stall.
// Synchronous reset empties every bucket at once (no clearing pass) and zeroes the total.
module chained_hash_table
  import cht_pkg::*;
#(
  parameter int BUCKETS      = 11,
  parameter int BUCKET_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [KEY_W-1:0]    in_key,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [BUCKET_W-1:0] out_bucket,
  output logic [TOTAL_W-1:0]  out_total
);

  ctl_t ctl;
  sts_t sts;

  // Controller
  cht_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  // Datapath
  cht_dpath #(
    .BUCKETS      (BUCKETS),
    .BUCKET_DEPTH (BUCKET_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_cmd     (in_cmd),
    .in_key     (in_key),
    .ctl        (ctl),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_bucket (out_bucket),
    .out_total  (out_total)
  );

endmodule
